### hw/rtl/fifo_page_replacement_unit_assert.svh
// Assertion macros shared by the checker files of the page replacement unit.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef FIFO_PAGE_REPLACEMENT_UNIT_ASSERT_SVH
`define FIFO_PAGE_REPLACEMENT_UNIT_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define FPR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("fpr assertion failed");

// An implication, checked in the same cycle.
`define FPR_ASSERT_IMPL(lbl, ante, cons) \
  `FPR_ASSERT(lbl, (ante) |-> (cons))

// An implication, checked in the next cycle.
`define FPR_ASSERT_NEXT(lbl, ante, cons) \
  `FPR_ASSERT(lbl, (ante) |=> (cons))

`endif

### hw/rtl/fpr_pkg.sv
// ----------------------------------------------------------------------------
// fpr_pkg
// Types and fixed widths of the FIFO page replacement unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fpr_pkg;

  localparam int unsigned PAGE_BITS = 16;
  localparam int unsigned SLOT_OUT_W = 4;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned CFG_W = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [COUNT_W-1:0] count_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

endpackage

`default_nettype wire

### hw/rtl/fpr_page_if.sv
// ----------------------------------------------------------------------------
// fpr_page_if
// Valid/ready channel that carries one page reference per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpr_page_if;
  logic valid;
  logic ready;
  logic [fpr_pkg::PAGE_BITS-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink (input valid, input page_number, output ready);
endinterface

`default_nettype wire

### hw/rtl/fpr_result_if.sv
// ----------------------------------------------------------------------------
// fpr_result_if
// Valid/ready channel that carries one lookup result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpr_result_if;
  logic valid;
  logic ready;
  logic page_hit;
  logic [fpr_pkg::SLOT_OUT_W-1:0] slot_written;
  logic [fpr_pkg::COUNT_W-1:0] fault_total;
  logic [fpr_pkg::COUNT_W-1:0] hit_total;

  modport source (output valid, output page_hit, output slot_written,
                  output fault_total, output hit_total, input ready);
  modport sink (input valid, input page_hit, input slot_written,
                input fault_total, input hit_total, output ready);
endinterface

`default_nettype wire

### hw/rtl/fpr_cfg_if.sv
// ----------------------------------------------------------------------------
// fpr_cfg_if
// Valid/ready write channel for the frame count register.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpr_cfg_if;
  logic valid;
  logic ready;
  logic [fpr_pkg::CFG_W-1:0] frames_in_use;

  modport source (output valid, output frames_in_use, input ready);
  modport sink (input valid, input frames_in_use, output ready);
endinterface

`default_nettype wire

### hw/rtl/fpr_ctrl.sv
// ----------------------------------------------------------------------------
// fpr_ctrl
// Controller: takes a reference into the datapath, then commits the lookup
// when the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output fpr_pkg::cmd_t      cmd_o
);
  import fpr_pkg::*;

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_LOOKUP = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic commit;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // The output register may be refilled in the cycle its beat is taken.
  assign commit = (state_q == S_LOOKUP) && (!out_valid_q || out_ready_i);

  assign cmd_o.capture = in_valid_i && in_ready_o;
  assign cmd_o.commit  = commit;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (commit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/fpr_datapath.sv
// ----------------------------------------------------------------------------
// fpr_datapath
// Frame store, parallel lookup, round-robin pointer and saturating counters.
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_datapath #(
  parameter int unsigned MAX_FRAMES = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire fpr_pkg::cmd_t                 cmd_i,
  input  wire logic [fpr_pkg::PAGE_BITS-1:0] page_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [fpr_pkg::CFG_W-1:0]     cfg_data_i,
  output logic                               page_hit_o,
  output logic [fpr_pkg::SLOT_OUT_W-1:0]     slot_written_o,
  output logic [fpr_pkg::COUNT_W-1:0]        fault_total_o,
  output logic [fpr_pkg::COUNT_W-1:0]        hit_total_o
);
  import fpr_pkg::*;

  localparam int unsigned SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned NCLOG  = $clog2(MAX_FRAMES + 1);
  localparam int unsigned CNT_W  = (NCLOG > CFG_W) ? NCLOG : CFG_W;

  page_t              pages_q [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] valid_q;
  page_t              page_q;
  logic [CFG_W-1:0]   cfg_q;
  logic [SLOT_W-1:0]  next_slot_q, next_slot_d;
  count_t             fault_q, hit_q;
  logic               res_hit_q;
  logic [SLOT_OUT_W-1:0] res_slot_q;

  logic [CNT_W-1:0]   n_act;
  logic               hit;
  logic [SLOT_W-1:0]  slot_sel;
  logic [CNT_W-1:0]   slot_plus;

  // A count of zero means one frame; counts above the store saturate.
  always_comb begin
    n_act = CNT_W'(cfg_q);
    if (cfg_q == '0) begin
      n_act = CNT_W'(1);
    end
    if (n_act > CNT_W'(MAX_FRAMES)) begin
      n_act = CNT_W'(MAX_FRAMES);
    end
  end

  always_comb begin
    hit = 1'b0;
    for (int unsigned i = 0; i < MAX_FRAMES; i++) begin
      if ((CNT_W'(i) < n_act) && valid_q[i] && (pages_q[i] == page_q)) begin
        hit = 1'b1;
      end
    end
  end

  // A pointer left beyond a reduced frame count restarts at frame zero.
  assign slot_sel  = (CNT_W'(next_slot_q) < n_act) ? next_slot_q : '0;
  assign slot_plus = CNT_W'(slot_sel) + CNT_W'(1);
  assign next_slot_d = (slot_plus >= n_act) ? '0 : slot_plus[SLOT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      next_slot_q <= '0;
      fault_q     <= '0;
      hit_q       <= '0;
      cfg_q       <= CFG_RESET;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_data_i;
      end
      if (cmd_i.commit) begin
        if (hit) begin
          if (hit_q != '1) begin
            hit_q <= hit_q + COUNT_W'(1);
          end
        end else begin
          if (fault_q != '1) begin
            fault_q <= fault_q + COUNT_W'(1);
          end
          valid_q[slot_sel] <= 1'b1;
          next_slot_q       <= next_slot_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      page_q <= page_i;
    end
    if (cmd_i.commit) begin
      res_hit_q <= hit;
      if (hit) begin
        res_slot_q <= '0;
      end else begin
        res_slot_q        <= SLOT_OUT_W'(slot_sel);
        pages_q[slot_sel] <= page_q;
      end
    end
  end

  // Counters change only on a commit, which waits for the output register,
  // so they show the totals of the held result.
  assign page_hit_o     = res_hit_q;
  assign slot_written_o = res_slot_q;
  assign fault_total_o  = fault_q;
  assign hit_total_o    = hit_q;

endmodule

`default_nettype wire

### hw/rtl/fifo_page_replacement_unit.sv
// A FIFO page replacement unit: each beat on page_i is one page reference.
// It is compared at once against all valid frames below the configured frame
// count; a hit counts a hit, a miss counts a fault and loads the page into the
// next frame in round-robin order. One result beat leaves per reference. An
// item is registered while idle, then looked up and the frame store updated
// in the lookup state; no new reference is taken until it commits, and a
// commit waits while result_o holds an untaken beat. The user must write
// the frame count register via cfg_i (always ready) only while the unit is
// idle (not enforced). No clearing pass: frame valid bits clear at reset.
`default_nettype none

module fifo_page_replacement_unit #(
  parameter int unsigned MAX_FRAMES = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  fpr_page_if.sink       page_i,
  fpr_cfg_if.sink        cfg_i,
  fpr_result_if.source   result_o
);
  import fpr_pkg::*;

  cmd_t cmd;

  assign cfg_i.ready = 1'b1;

  fpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (page_i.valid),
    .in_ready_o  (page_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .cmd_o       (cmd)
  );

  fpr_datapath #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .page_i         (page_i.page_number),
    .cfg_we_i       (cfg_i.valid),
    .cfg_data_i     (cfg_i.frames_in_use),
    .page_hit_o     (result_o.page_hit),
    .slot_written_o (result_o.slot_written),
    .fault_total_o  (result_o.fault_total),
    .hit_total_o    (result_o.hit_total)
  );

endmodule

`default_nettype wire

### hw/rtl/fpr_checker.sv
// ----------------------------------------------------------------------------
// fpr_checker
// Port-level checks of the page replacement unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fifo_page_replacement_unit_assert.svh"

module fpr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic        page_hit_i,
  input wire logic [3:0]  slot_written_i,
  input wire logic [31:0] fault_total_i,
  input wire logic [31:0] hit_total_i
);

  // A stalled result beat keeps its contents.
  `FPR_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
                   out_valid_i && $stable(page_hit_i) && $stable(slot_written_i)
                   && $stable(fault_total_i) && $stable(hit_total_i))

  // A hit loads no frame.
  `FPR_ASSERT_IMPL(a_hit_slot_zero, out_valid_i && page_hit_i, slot_written_i == 4'd0)

  // A fault result already includes its own fault in the total.
  `FPR_ASSERT_IMPL(a_fault_counted, out_valid_i && !page_hit_i, fault_total_i != 32'd0)

  // A hit result already includes its own hit in the total.
  `FPR_ASSERT_IMPL(a_hit_counted, out_valid_i && page_hit_i, hit_total_i != 32'd0)

endmodule

bind fifo_page_replacement_unit fpr_checker u_fpr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .page_hit_i     (result_o.page_hit),
  .slot_written_i (result_o.slot_written),
  .fault_total_i  (result_o.fault_total),
  .hit_total_i    (result_o.hit_total)
);

`default_nettype wire

### tb/tb_fifo_page_replacement_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fifo_page_replacement_unit
// Self-checking bench for the FIFO page replacement unit. Page references go
// in on the page channel. A local copy of the frame store, the round-robin
// pointer and the counters predicts each result beat, which is checked field
// by field. The bench covers directed corner cases of the frame count, then
// random reference streams over several frame counts, with random idling on
// both channels.
// ----------------------------------------------------------------------------
module tb_fifo_page_replacement_unit;
  import fpr_pkg::*;

  localparam int unsigned NUM_FRAMES = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned PHASE_ITEMS = 250;

  typedef struct packed {
    logic hit;
    logic [SLOT_OUT_W-1:0] slot;
    count_t faults;
    count_t hits;
  } lookup_t;

  logic clk;
  logic rst_n;

  fpr_page_if page_if ();
  fpr_cfg_if cfg_if ();
  fpr_result_if result_if ();

  fifo_page_replacement_unit #(
    .MAX_FRAMES(NUM_FRAMES)
  ) u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .page_i  (page_if),
    .cfg_i   (cfg_if),
    .result_o(result_if)
  );

  // Local copy of the unit's state.
  page_t frame_page_q[NUM_FRAMES];
  logic frame_valid_q[NUM_FRAMES];
  int unsigned next_frame;
  count_t fault_count;
  count_t hit_count;
  logic [CFG_W-1:0] frame_count_reg;

  lookup_t expected_lookups[$];
  lookup_t oldest_lookup;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit idle_en = 1'b0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side back-pressure in random bursts.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      result_if.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 18);
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  function automatic int unsigned resident_frames();
    if (frame_count_reg == 0) return 1;
    if (frame_count_reg > NUM_FRAMES) return NUM_FRAMES;
    return frame_count_reg;
  endfunction

  function automatic void predict_lookup(input page_t pg);
    int unsigned active;
    int unsigned slot;
    lookup_t res;
    active = resident_frames();
    res = '0;
    for (int i = 0; i < active; i++) begin
      if (frame_valid_q[i] && frame_page_q[i] == pg) res.hit = 1'b1;
    end
    if (res.hit) begin
      if (hit_count != '1) hit_count++;
    end else begin
      if (fault_count != '1) fault_count++;
      // A pointer left beyond a shrunk frame count restarts at frame 0.
      slot = (next_frame < active) ? next_frame : 0;
      frame_page_q[slot] = pg;
      frame_valid_q[slot] = 1'b1;
      next_frame = (slot + 1 >= active) ? 0 : slot + 1;
      res.slot = slot[SLOT_OUT_W-1:0];
    end
    res.faults = fault_count;
    res.hits = hit_count;
    expected_lookups.push_back(res);
  endfunction

  always @(posedge clk) begin
    if (rst_n && result_if.valid && result_if.ready) begin
      if (expected_lookups.size() == 0) begin
        note_failure($sformatf("unexpected result beat: hit %0b slot %0d faults %0d hits %0d",
                               result_if.page_hit, result_if.slot_written,
                               result_if.fault_total, result_if.hit_total));
      end else begin
        oldest_lookup = expected_lookups.pop_front();
        if (result_if.page_hit !== oldest_lookup.hit)
          note_failure($sformatf("page_hit: expected %0b, got %0b",
                                 oldest_lookup.hit, result_if.page_hit));
        if (result_if.slot_written !== oldest_lookup.slot)
          note_failure($sformatf("slot_written: expected %0d, got %0d",
                                 oldest_lookup.slot, result_if.slot_written));
        if (result_if.fault_total !== oldest_lookup.faults)
          note_failure($sformatf("fault_total: expected %0d, got %0d",
                                 oldest_lookup.faults, result_if.fault_total));
        if (result_if.hit_total !== oldest_lookup.hits)
          note_failure($sformatf("hit_total: expected %0d, got %0d",
                                 oldest_lookup.hits, result_if.hit_total));
      end
    end
  end

  task automatic send_page(input page_t pg);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      page_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    page_if.valid <= 1'b1;
    page_if.page_number <= pg;
    do @(posedge clk); while (!page_if.ready);
    predict_lookup(pg);
  endtask

  // The sender holds off until every outstanding result beat has come back.
  task automatic drain_lookups();
    page_if.valid <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_frame_count(input logic [CFG_W-1:0] count);
    cfg_if.valid <= 1'b1;
    cfg_if.frames_in_use <= count;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    frame_count_reg = count;
  endtask

  task automatic run_random_phase(input logic [CFG_W-1:0] count, input int unsigned n_items);
    page_t pool[$];
    page_t pg;
    page_t one_hot;
    int unsigned pick;
    drain_lookups();
    write_frame_count(count);
    // A pool slightly larger than the frame set gives both hits and evictions.
    repeat (resident_frames() + 3) pool.push_back(page_t'($urandom));
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      one_hot = page_t'(1) << $urandom_range(0, PAGE_BITS - 1);
      if (pick < 75) begin
        pg = pool[$urandom_range(0, pool.size() - 1)];
      end else if (pick < 90) begin
        pg = page_t'($urandom);
      end else begin
        case ($urandom_range(0, 3))
          0: pg = '0;
          1: pg = '1;
          2: pg = one_hot;
          default: pg = ~one_hot;
        endcase
      end
      send_page(pg);
    end
  endtask

  // Reset frame count: misses fill frames in order, repeats hit.
  task automatic test_hit_and_miss();
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'hAAAA);
    send_page(16'h5555);
  endtask

  // Shrink the frame count below the pointer; the next fault loads frame 0.
  task automatic test_pointer_past_count();
    drain_lookups();
    write_frame_count(5'd2);
    send_page(16'h1234);
    send_page(16'h0000);
    send_page(16'hFFFF);
  endtask

  // A frame count of zero behaves as a single frame.
  task automatic test_single_frame();
    drain_lookups();
    write_frame_count(5'd0);
    send_page(16'h0007);
    send_page(16'h0007);
    send_page(16'h0008);
    send_page(16'h0007);
  endtask

  // Counts above the frame store saturate; older resident pages become visible again.
  task automatic test_count_above_max();
    drain_lookups();
    write_frame_count(5'd31);
    send_page(16'hAAAA);
    send_page(16'h5555);
    send_page(16'h0000);
    send_page(16'h0009);
  endtask

  task automatic test_random_mix();
    run_random_phase(5'd1, PHASE_ITEMS);
    run_random_phase(5'd16, PHASE_ITEMS);
    run_random_phase(5'd17, PHASE_ITEMS);
    run_random_phase(5'd3, PHASE_ITEMS);
    run_random_phase(5'd0, PHASE_ITEMS);
    run_random_phase(5'd31, PHASE_ITEMS);
    run_random_phase(5'd8, PHASE_ITEMS);
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_steady_stream();
    idle_en = 1'b0;
    run_random_phase(CFG_W'($urandom_range(0, 31)), PHASE_ITEMS);
  endtask

  initial begin
    rst_n = 1'b0;
    page_if.valid = 1'b0;
    page_if.page_number = '0;
    cfg_if.valid = 1'b0;
    cfg_if.frames_in_use = '0;
    result_if.ready = 1'b0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      frame_page_q[i] = '0;
      frame_valid_q[i] = 1'b0;
    end
    next_frame = 0;
    fault_count = '0;
    hit_count = '0;
    frame_count_reg = CFG_RESET;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_en = 1'b1;

    test_hit_and_miss();
    test_pointer_past_count();
    test_single_frame();
    test_count_above_max();
    test_random_mix();
    test_steady_stream();

    drain_lookups();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && expected_lookups.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### fifo_page_replacement_unit.f
+incdir+hw/rtl
hw/rtl/fpr_pkg.sv
hw/rtl/fpr_page_if.sv
hw/rtl/fpr_result_if.sv
hw/rtl/fpr_cfg_if.sv
hw/rtl/fpr_ctrl.sv
hw/rtl/fpr_datapath.sv
hw/rtl/fifo_page_replacement_unit.sv
hw/rtl/fpr_checker.sv
tb/tb_fifo_page_replacement_unit.sv
